/* rtl/core/owm_pkg.sv */
// Shared types, codes and tables for the one-wire temperature master.
package owm_pkg;

    // Tick counter width and the largest count it holds
    localparam int CountWidth = 10;
    localparam int CfgWidth   = 10;
    localparam int NumRegs    = 7;

    typedef logic [CountWidth-1:0] len_t;
    typedef len_t [NumRegs-1:0] cfg_lens_t;

    localparam len_t CountMax = '1;

    // Configuration register indexes
    localparam logic [2:0] REG_PRE_HIGH      = 3'd0;
    localparam logic [2:0] REG_RESET_LOW     = 3'd1;
    localparam logic [2:0] REG_PRESENCE_WAIT = 3'd2;
    localparam logic [2:0] REG_RESET_REC     = 3'd3;
    localparam logic [2:0] REG_SLOT_START    = 3'd4;
    localparam logic [2:0] REG_SLOT_HOLD     = 3'd5;
    localparam logic [2:0] REG_SLOT_REC      = 3'd6;

    // Register reset values, as written
    localparam logic [CfgWidth-1:0] RST_PRE_HIGH      = 10'd10;
    localparam logic [CfgWidth-1:0] RST_RESET_LOW     = 10'd500;
    localparam logic [CfgWidth-1:0] RST_PRESENCE_WAIT = 10'd40;
    localparam logic [CfgWidth-1:0] RST_RESET_REC     = 10'd200;
    localparam logic [CfgWidth-1:0] RST_SLOT_START    = 10'd5;
    localparam logic [CfgWidth-1:0] RST_SLOT_HOLD     = 10'd80;
    localparam logic [CfgWidth-1:0] RST_SLOT_REC      = 10'd5;

    // Command codes on the mode field
    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_RESET = 3'd1;
    localparam logic [2:0] MODE_WRITE = 3'd2;
    localparam logic [2:0] MODE_READ  = 3'd3;
    localparam logic [2:0] MODE_TEMP  = 3'd4;

    // ROM and function commands
    localparam logic [7:0] CMD_SKIP_ROM  = 8'hcc;
    localparam logic [7:0] CMD_CONVERT   = 8'h44;
    localparam logic [7:0] CMD_READ_PAD  = 8'hbe;
    localparam logic [2:0] STEP_LOW_BYTE = 3'd6;
    localparam logic [2:0] STEP_LAST     = 3'd7;

    typedef enum logic [1:0] {
        OP_RESET,
        OP_WRITE,
        OP_READ
    } op_kind_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RPRE,
        PH_RLOW,
        PH_RWAIT,
        PH_RREC,
        PH_SSTART,
        PH_SHOLD,
        PH_SREC
    } phase_t;

    // Sequencer state
    typedef struct packed {
        phase_t     phase;
        len_t       tick_count;
        logic [2:0] bit_index;
        logic [7:0] shift_byte;
        logic [2:0] sequence_step;
        logic       temp_seq;
        logic       op_read;
        logic       presence_flag;
        logic [7:0] low_byte_hold;
        logic [15:0] temperature_hold;
        logic [7:0] read_value;
    } seq_state_t;

    // One result of the sequencer
    typedef struct packed {
        logic        drive_low;
        logic        busy;
        logic        done;
        logic        no_presence;
        logic [7:0]  read_value;
        logic [15:0] temperature_word;
    } seq_result_t;

    // Temperature sequence: operation for each step
    function automatic op_kind_t temp_kind(input logic [2:0] step);
        op_kind_t k;
        case (step)
            3'd0, 3'd3: k = OP_RESET;
            3'd6, 3'd7: k = OP_READ;
            default:    k = OP_WRITE;
        endcase
        return k;
    endfunction

    // Temperature sequence: byte sent at each write step
    function automatic logic [7:0] temp_byte(input logic [2:0] step);
        logic [7:0] b;
        case (step)
            3'd1, 3'd4: b = CMD_SKIP_ROM;
            3'd2:       b = CMD_CONVERT;
            3'd5:       b = CMD_READ_PAD;
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

    // Effective phase length: zero acts as one, saturate to the counter range
    function automatic len_t clamp_len(input logic [CfgWidth-1:0] v);
        len_t r;
        if (16'(v) > 16'(CountMax))
            r = CountMax;
        else if (v == '0)
            r = len_t'(1);
        else
            r = len_t'(v);
        return r;
    endfunction

endpackage

/* rtl/core/owm_cfg.sv */
// Timing configuration registers, stored as effective phase lengths.
module owm_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [2:0]                   cfg_index,
    input  logic [owm_pkg::CfgWidth-1:0] cfg_data,
    output owm_pkg::cfg_lens_t           lens
);
    import owm_pkg::*;

    cfg_lens_t lens_reg;
    cfg_lens_t lens_next;
    len_t      wr_len;

    assign cfg_ready = 1'b1;
    assign wr_len    = clamp_len(cfg_data);

    // Register write decode
    always_comb
    begin
        lens_next = lens_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PRE_HIGH:      lens_next[REG_PRE_HIGH]      = wr_len;
                REG_RESET_LOW:     lens_next[REG_RESET_LOW]     = wr_len;
                REG_PRESENCE_WAIT: lens_next[REG_PRESENCE_WAIT] = wr_len;
                REG_RESET_REC:     lens_next[REG_RESET_REC]     = wr_len;
                REG_SLOT_START:    lens_next[REG_SLOT_START]    = wr_len;
                REG_SLOT_HOLD:     lens_next[REG_SLOT_HOLD]     = wr_len;
                REG_SLOT_REC:      lens_next[REG_SLOT_REC]      = wr_len;
                default:           lens_next = lens_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lens_reg[REG_PRE_HIGH]      <= clamp_len(RST_PRE_HIGH);
            lens_reg[REG_RESET_LOW]     <= clamp_len(RST_RESET_LOW);
            lens_reg[REG_PRESENCE_WAIT] <= clamp_len(RST_PRESENCE_WAIT);
            lens_reg[REG_RESET_REC]     <= clamp_len(RST_RESET_REC);
            lens_reg[REG_SLOT_START]    <= clamp_len(RST_SLOT_START);
            lens_reg[REG_SLOT_HOLD]     <= clamp_len(RST_SLOT_HOLD);
            lens_reg[REG_SLOT_REC]      <= clamp_len(RST_SLOT_REC);
        end
        else
        begin
            lens_reg <= lens_next;
        end
    end

    assign lens = lens_reg;

endmodule

/* rtl/core/owm_seq.sv */
// Bus sequencer: phase timing, time slots and the temperature command list.
module owm_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick,
    input  logic [2:0]           mode,
    input  logic [7:0]           data_byte,
    input  logic                 line_level,
    input  owm_pkg::cfg_lens_t   lens,
    output owm_pkg::seq_result_t result
);
    import owm_pkg::*;

    seq_state_t st_reg;
    seq_state_t st_next;

    // Launch one operation of a command
    function automatic seq_state_t start_op(input seq_state_t s, input op_kind_t kind,
                                            input logic [7:0] b);
        seq_state_t r;
        r            = s;
        r.tick_count = '0;
        r.bit_index  = '0;
        r.op_read    = (kind == OP_READ);
        if (kind == OP_RESET)
            r.phase = PH_RPRE;
        else
        begin
            r.phase      = PH_SSTART;
            r.shift_byte = (kind == OP_WRITE) ? b : 8'h00;
        end
        return r;
    endfunction

    // Close one operation; temperature command moves to its next step
    function automatic seq_state_t finish_op(input seq_state_t s);
        seq_state_t r;
        logic [2:0] nstep;
        r     = s;
        nstep = s.sequence_step + 3'd1;
        if (!s.temp_seq)
        begin
            if (s.op_read)
                r.read_value = s.shift_byte;
            r.phase = PH_IDLE;
        end
        else
        begin
            if (s.sequence_step == STEP_LOW_BYTE)
                r.low_byte_hold = s.shift_byte;
            if (s.sequence_step == STEP_LAST)
            begin
                r.temperature_hold = {s.shift_byte, s.low_byte_hold};
                r.phase            = PH_IDLE;
                r.temp_seq         = 1'b0;
            end
            else
            begin
                r.sequence_step = nstep;
                r = start_op(r, temp_kind(nstep), temp_byte(nstep));
            end
        end
        return r;
    endfunction

    // Next state and result of one tick
    always_comb
    begin
        seq_state_t s;
        len_t       len;
        len_t       tc_inc;
        logic       drive;
        logic       busy;
        logic       done;
        logic       fin_done;

        s     = st_reg;
        len   = len_t'(1);
        drive = 1'b0;
        busy  = 1'b0;
        done  = 1'b0;

        // Command taken only when idle; unknown modes are plain ticks
        if (s.phase == PH_IDLE)
        begin
            case (mode)
                MODE_RESET:
                begin
                    s.sequence_step = '0;
                    s.temp_seq      = 1'b0;
                    s = start_op(s, OP_RESET, 8'h00);
                end
                MODE_WRITE:
                begin
                    s.sequence_step = '0;
                    s.temp_seq      = 1'b0;
                    s = start_op(s, OP_WRITE, data_byte);
                end
                MODE_READ:
                begin
                    s.sequence_step = '0;
                    s.temp_seq      = 1'b0;
                    s = start_op(s, OP_READ, 8'h00);
                end
                MODE_TEMP:
                begin
                    s.sequence_step = '0;
                    s.temp_seq      = 1'b1;
                    s = start_op(s, temp_kind(3'd0), temp_byte(3'd0));
                end
                default:
                begin
                    s = s;
                end
            endcase
        end

        fin_done = !s.temp_seq || (s.sequence_step == STEP_LAST);
        tc_inc   = s.tick_count + len_t'(1);

        if (s.phase != PH_IDLE)
        begin
            busy = 1'b1;
            // Per-phase drive, sampling and length
            case (s.phase)
                PH_RPRE:  len = lens[REG_PRE_HIGH];
                PH_RLOW:
                begin
                    drive = 1'b1;
                    len   = lens[REG_RESET_LOW];
                end
                PH_RWAIT: len = lens[REG_PRESENCE_WAIT];
                PH_RREC:
                begin
                    if (s.tick_count == '0)
                        s.presence_flag = line_level;
                    len = lens[REG_RESET_REC];
                end
                PH_SSTART:
                begin
                    drive = 1'b1;
                    len   = lens[REG_SLOT_START];
                end
                PH_SHOLD:
                begin
                    if (s.op_read)
                    begin
                        if (s.tick_count == '0)
                            s.shift_byte = {line_level, s.shift_byte[7:1]};
                    end
                    else
                        drive = !s.shift_byte[0];
                    len = lens[REG_SLOT_HOLD];
                end
                default:  len = lens[REG_SLOT_REC];
            endcase

            s.tick_count = tc_inc;
            // Phase end
            if (tc_inc >= len || tc_inc == '0)
            begin
                s.tick_count = '0;
                case (s.phase)
                    PH_RPRE:   s.phase = PH_RLOW;
                    PH_RLOW:   s.phase = PH_RWAIT;
                    PH_RWAIT:  s.phase = PH_RREC;
                    PH_RREC:
                    begin
                        done = fin_done;
                        s    = finish_op(s);
                    end
                    PH_SSTART: s.phase = PH_SHOLD;
                    PH_SHOLD:  s.phase = PH_SREC;
                    default:
                    begin
                        if (!s.op_read)
                            s.shift_byte = {1'b0, s.shift_byte[7:1]};
                        if (s.bit_index == 3'd7)
                        begin
                            done = fin_done;
                            s    = finish_op(s);
                        end
                        else
                        begin
                            s.bit_index = s.bit_index + 3'd1;
                            s.phase     = PH_SSTART;
                        end
                    end
                endcase
            end
        end

        st_next                 = s;
        result.drive_low        = drive;
        result.busy             = busy;
        result.done             = done;
        result.no_presence      = s.presence_flag;
        result.read_value       = s.read_value;
        result.temperature_word = s.temperature_hold;
    end

    // State advances once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '{phase: PH_IDLE, default: '0};
        end
        else if (tick)
        begin
            st_reg <= st_next;
        end
    end

endmodule

/* rtl/core/one_wire_temperature_master.sv */
// Top level of the one-wire temperature master: tick channel, config port, result register.
// One-wire bus master stepped by one-microsecond ticks. Every accepted input transaction is
// one tick and yields exactly one result transaction carrying the line drive and status.
// A tick is taken every clock cycle: the sequencer state updates in the same cycle the tick
// is accepted, and the result sits in a single output register, so the block stalls its
// input only while that register is full and the consumer stalls. The result is valid in the
// cycle after tick acceptance. Timing registers are written through the config port
// (ready is always high) and should only be changed while no command is in progress.
module one_wire_temperature_master (
    input  logic                         clk,
    input  logic                         rst_n,
    // Tick channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   mode,
    input  logic [7:0]                   data_byte,
    input  logic                         line_level,
    // Result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         drive_low,
    output logic                         busy_res,
    output logic                         done_res,
    output logic                         no_presence,
    output logic [7:0]                   read_value,
    output logic [15:0]                  temperature_word,
    // Configuration channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [2:0]                   cfg_index,
    input  logic [owm_pkg::CfgWidth-1:0] cfg_data
);
    import owm_pkg::*;

    cfg_lens_t   lens;
    seq_result_t result;
    seq_result_t res_reg;
    logic        out_valid_reg;
    logic        tick;

    assign in_stall = out_valid_reg && out_stall;
    assign tick     = in_valid && !in_stall;

    owm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .lens      (lens)
    );

    owm_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .mode       (mode),
        .data_byte  (data_byte),
        .line_level (line_level),
        .lens       (lens),
        .result     (result)
    );

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (tick)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            res_reg <= result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign drive_low        = res_reg.drive_low;
    assign busy_res         = res_reg.busy;
    assign done_res         = res_reg.done;
    assign no_presence      = res_reg.no_presence;
    assign read_value       = res_reg.read_value;
    assign temperature_word = res_reg.temperature_word;

endmodule

/* rtl/core/owm_checker.sv */
// Port-level checks on the one-wire temperature master, bound to the top level.
module owm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        drive_low,
    input logic        busy_res,
    input logic        done_res,
    input logic [15:0] temperature_word
);

    // A completing tick is always part of a busy sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> busy_res)
        else $error("done without busy");

    // The line is never pulled low while no command runs
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !busy_res |-> !drive_low)
        else $error("line driven while idle");

    // Input is only held off while the result register is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with free result register");

    // Every accepted tick shows a result transaction on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted tick without result");

    // A stalled result transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(temperature_word))
        else $error("stalled result changed");

endmodule

bind one_wire_temperature_master owm_checker u_owm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .drive_low        (drive_low),
    .busy_res         (busy_res),
    .done_res         (done_res),
    .temperature_word (temperature_word)
);

/* test/tb_one_wire_temperature_master.sv */
// Self-checking testbench for the one-wire temperature master.
`timescale 1ns / 1ps

module tb_one_wire_temperature_master;
    import owm_pkg::*;

    // Tracks the sequencer tick by tick and holds the results it should produce
    class temp_master_scoreboard;
        seq_result_t         expected_q[$];
        int                  failures;
        int                  checked;
        int                  ticks;
        int                  done_count;
        int                  temp_count;

        // Sequencer state mirror
        phase_t              ph;
        len_t                cnt;
        logic [2:0]          bit_idx;
        logic [7:0]          shreg;
        logic [2:0]          step;
        logic [7:0]          low_hold;
        logic                presence;
        logic [15:0]         temp_hold;
        logic                in_temp;
        logic                reading;
        logic [7:0]          rd_byte;
        logic [CfgWidth-1:0] lens [NumRegs];

        // Temperature sequence: operation and command byte per step
        op_kind_t            step_op [8];
        logic [7:0]          step_byte [8];

        function new();
            step_op   = '{OP_RESET, OP_WRITE, OP_WRITE, OP_RESET,
                          OP_WRITE, OP_WRITE, OP_READ, OP_READ};
            step_byte = '{8'h00, CMD_SKIP_ROM, CMD_CONVERT, 8'h00,
                          CMD_SKIP_ROM, CMD_READ_PAD, 8'h00, 8'h00};
            lens[REG_PRE_HIGH]      = RST_PRE_HIGH;
            lens[REG_RESET_LOW]     = RST_RESET_LOW;
            lens[REG_PRESENCE_WAIT] = RST_PRESENCE_WAIT;
            lens[REG_RESET_REC]     = RST_RESET_REC;
            lens[REG_SLOT_START]    = RST_SLOT_START;
            lens[REG_SLOT_HOLD]     = RST_SLOT_HOLD;
            lens[REG_SLOT_REC]      = RST_SLOT_REC;
            ph        = PH_IDLE;
            cnt       = '0;
            bit_idx   = '0;
            shreg     = '0;
            step      = '0;
            low_hold  = '0;
            presence  = 1'b0;
            temp_hold = '0;
            in_temp   = 1'b0;
            reading   = 1'b0;
            rd_byte   = '0;
        endfunction

        function void set_len(logic [2:0] idx, logic [CfgWidth-1:0] val);
            lens[idx] = val;
        endfunction

        function bit is_idle();
            return ph == PH_IDLE;
        endfunction

        // Zero acts as one; anything past the counter range saturates
        function len_t eff_len(logic [2:0] idx);
            if (lens[idx] == '0)
                return len_t'(1);
            if (lens[idx] > CountMax)
                return CountMax;
            return len_t'(lens[idx]);
        endfunction

        function void start_op(op_kind_t kind, logic [7:0] byte_val);
            cnt     = '0;
            bit_idx = '0;
            reading = (kind == OP_READ);
            if (kind == OP_RESET)
                ph = PH_RPRE;
            else
            begin
                ph    = PH_SSTART;
                shreg = (kind == OP_WRITE) ? byte_val : 8'h00;
            end
        endfunction

        // End of one operation; returns 1 when the whole command is complete
        function bit finish_op();
            if (!in_temp)
            begin
                if (reading)
                    rd_byte = shreg;
                ph = PH_IDLE;
                return 1'b1;
            end
            if (step == STEP_LOW_BYTE)
                low_hold = shreg;
            if (step == STEP_LAST)
            begin
                temp_hold = {shreg, low_hold};
                ph        = PH_IDLE;
                in_temp   = 1'b0;
                temp_count++;
                return 1'b1;
            end
            step = step + 1'b1;
            start_op(step_op[step], step_byte[step]);
            return 1'b0;
        endfunction

        // One accepted tick: advance the mirror and queue the result it yields
        function void note_tick(logic [2:0] md, logic [7:0] db, logic ln);
            seq_result_t want;
            len_t        span;
            want = '0;
            span = len_t'(1);
            ticks++;
            if (ph == PH_IDLE && md >= MODE_RESET && md <= MODE_TEMP)
            begin
                step    = '0;
                in_temp = (md == MODE_TEMP);
                case (md)
                    MODE_RESET: start_op(OP_RESET, 8'h00);
                    MODE_WRITE: start_op(OP_WRITE, db);
                    MODE_READ:  start_op(OP_READ, 8'h00);
                    default:    start_op(step_op[0], step_byte[0]);
                endcase
            end
            if (ph != PH_IDLE)
            begin
                want.busy = 1'b1;
                case (ph)
                    PH_RPRE:
                        span = eff_len(REG_PRE_HIGH);
                    PH_RLOW:
                    begin
                        want.drive_low = 1'b1;
                        span = eff_len(REG_RESET_LOW);
                    end
                    PH_RWAIT:
                        span = eff_len(REG_PRESENCE_WAIT);
                    PH_RREC:
                    begin
                        // presence is sampled on the first recovery tick
                        if (cnt == '0)
                            presence = ln;
                        span = eff_len(REG_RESET_REC);
                    end
                    PH_SSTART:
                    begin
                        want.drive_low = 1'b1;
                        span = eff_len(REG_SLOT_START);
                    end
                    PH_SHOLD:
                    begin
                        if (reading)
                        begin
                            if (cnt == '0)
                                shreg = {ln, shreg[7:1]};
                        end
                        else
                            want.drive_low = ~shreg[0];
                        span = eff_len(REG_SLOT_HOLD);
                    end
                    default:
                        span = eff_len(REG_SLOT_REC);
                endcase
                cnt = cnt + 1'b1;
                if (cnt >= span || cnt == '0)
                begin
                    cnt = '0;
                    case (ph)
                        PH_RPRE:   ph = PH_RLOW;
                        PH_RLOW:   ph = PH_RWAIT;
                        PH_RWAIT:  ph = PH_RREC;
                        PH_RREC:   want.done = finish_op();
                        PH_SSTART: ph = PH_SHOLD;
                        PH_SHOLD:  ph = PH_SREC;
                        default:
                        begin
                            if (!reading)
                                shreg = shreg >> 1;
                            if (bit_idx == 3'd7)
                                want.done = finish_op();
                            else
                            begin
                                bit_idx = bit_idx + 1'b1;
                                ph      = PH_SSTART;
                            end
                        end
                    endcase
                end
            end
            if (want.done)
                done_count++;
            want.no_presence      = presence;
            want.read_value       = rd_byte;
            want.temperature_word = temp_hold;
            expected_q.push_back(want);
        endfunction

        function void report(string what, seq_result_t got, seq_result_t want);
            failures++;
            if (failures <= 10)
            begin
                $display("%s (exp/got): drive_low %b/%b busy %b/%b done %b/%b no_presence %b/%b",
                         what, want.drive_low, got.drive_low, want.busy, got.busy,
                         want.done, got.done, want.no_presence, got.no_presence);
                $display("    read_value %h/%h temperature_word %h/%h",
                         want.read_value, got.read_value,
                         want.temperature_word, got.temperature_word);
            end
        endfunction

        // One accepted result against the oldest expectation
        function void check_result(seq_result_t got);
            seq_result_t want;
            if (expected_q.size() == 0)
            begin
                report("Result with nothing outstanding", got, '0);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.drive_low !== want.drive_low || got.busy !== want.busy ||
                got.done !== want.done || got.no_presence !== want.no_presence ||
                got.read_value !== want.read_value ||
                got.temperature_word !== want.temperature_word)
                report($sformatf("Mismatch on result %0d", checked), got, want);
        endfunction
    endclass

    localparam int         CycleLimit     = 100_000;
    localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
    localparam int         LINE_RANDOM    = 0;
    localparam int         LINE_HIGH      = 1;
    localparam int         LINE_LOW       = 2;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [2:0]          mode;
    logic [7:0]          data_byte;
    logic                line_level;
    logic                out_valid;
    logic                out_stall;
    logic                drive_low;
    logic                busy_res;
    logic                done_res;
    logic                no_presence;
    logic [7:0]          read_value;
    logic [15:0]         temperature_word;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [2:0]          cfg_index;
    logic [CfgWidth-1:0] cfg_data;

    temp_master_scoreboard sb;
    logic [CfgWidth-1:0]   cfg_plan [NumRegs];
    seq_result_t           got_res;
    int                    cycles;
    int                    settings;
    int                    stall_left;
    int                    in_gap_pct;
    int                    out_gap_pct;
    int                    line_rule;
    bit                    quiet;

    one_wire_temperature_master dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode),
        .data_byte        (data_byte),
        .line_level       (line_level),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .drive_low        (drive_low),
        .busy_res         (busy_res),
        .done_res         (done_res),
        .no_presence      (no_presence),
        .read_value       (read_value),
        .temperature_word (temperature_word),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: random stall bursts, none once the run goes quiet
    always @(negedge clk)
    begin
        if (quiet)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 99) < out_gap_pct)
        begin
            stall_left = $urandom_range(1, 16) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Result check and watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CycleLimit)
        begin
            $display("Watchdog expired after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
        else if (rst_n && out_valid && !out_stall)
        begin
            got_res.drive_low        = drive_low;
            got_res.busy             = busy_res;
            got_res.done             = done_res;
            got_res.no_presence      = no_presence;
            got_res.read_value       = read_value;
            got_res.temperature_word = temperature_word;
            sb.check_result(got_res);
        end
    end

    function logic pick_line();
        if (line_rule == LINE_HIGH)
            return 1'b1;
        if (line_rule == LINE_LOW)
            return 1'b0;
        return 1'($urandom_range(0, 1));
    endfunction

    // One tick transaction, with an optional idle burst ahead of it
    task automatic send_tick(input logic [2:0] md, input logic [7:0] db, input logic ln);
        int gap;
        if (!quiet && $urandom_range(0, 99) < in_gap_pct)
        begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= md;
        data_byte  <= db;
        line_level <= ln;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_tick(md, db, ln);
        @(negedge clk);
    endtask

    // Issue a command, then keep ticking until the sequencer is idle again;
    // some of those ticks carry commands that must be ignored while busy
    task automatic run_command(input logic [2:0] md, input logic [7:0] db);
        send_tick(md, db, pick_line());
        while (!sb.is_idle())
        begin
            if ($urandom_range(0, 3) == 0)
                send_tick(3'($urandom_range(MODE_TICK, MODE_UNUSED_HI)),
                          8'($urandom_range(0, 255)), pick_line());
            else
                send_tick(MODE_TICK, 8'($urandom_range(0, 255)), pick_line());
        end
    endtask

    // Let every outstanding result come back before touching the timing registers
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // One register write; the caller drops cfg_valid after the last one
    task automatic write_reg(input logic [2:0] idx, input logic [CfgWidth-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_len(idx, val);
        @(negedge clk);
    endtask

    task automatic write_config();
        for (int i = 0; i < NumRegs; i++)
            write_reg(3'(i), cfg_plan[i]);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic fill_plan(input logic [CfgWidth-1:0] v);
        for (int i = 0; i < NumRegs; i++)
            cfg_plan[i] = v;
    endtask

    function logic [CfgWidth-1:0] rand_len();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        if (r == 7)
            return CfgWidth'($urandom_range(4, 6));
        return CfgWidth'($urandom_range(1, 3));
    endfunction

    initial
    begin
        int pick;
        sb          = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        mode        = MODE_TICK;
        data_byte   = 8'h00;
        line_level  = 1'b0;
        out_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_PRE_HIGH;
        cfg_data    = '0;
        cycles      = 0;
        settings    = 0;
        stall_left  = 0;
        in_gap_pct  = 15;
        out_gap_pct = 15;
        line_rule   = LINE_RANDOM;
        quiet       = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values of pre-high, presence wait, slot start and slot recovery;
        // the long phases are cut short so the run stays small
        write_reg(REG_RESET_LOW, CfgWidth'(1));
        write_reg(REG_RESET_REC, CfgWidth'(1));
        write_reg(REG_SLOT_HOLD, CfgWidth'(1));
        cfg_valid <= 1'b0;
        settings++;
        line_rule = LINE_HIGH;
        run_command(MODE_RESET, 8'h00);
        line_rule = LINE_RANDOM;
        run_command(MODE_READ, 8'h00);
        drain();

        // Shortest timings: write, read, temperature
        fill_plan(CfgWidth'(1));
        write_config();
        run_command(MODE_WRITE, 8'ha5);
        run_command(MODE_READ, 8'h3c);
        run_command(MODE_TEMP, 8'h00);
        // unknown modes and a bare tick on an idle sequencer
        for (int m = MODE_UNUSED_LO; m <= MODE_UNUSED_HI; m++)
            send_tick(3'(m), 8'($urandom_range(0, 255)), pick_line());
        send_tick(MODE_TICK, 8'h00, 1'b1);
        drain();

        // Zero lengths behave as one; reset with a presence pulse
        fill_plan('0);
        write_config();
        run_command(MODE_WRITE, 8'h5a);
        line_rule = LINE_LOW;
        run_command(MODE_RESET, 8'h00);
        drain();

        // Random phases: fresh short timings each, random command mix
        for (int p = 0; p < 2; p++)
        begin
            for (int i = 0; i < NumRegs; i++)
                cfg_plan[i] = rand_len();
            write_config();
            quiet = (p == 1);
            in_gap_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
            out_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
            pick = $urandom_range(0, 5);
            line_rule = (pick == 4) ? LINE_HIGH : (pick == 5) ? LINE_LOW : LINE_RANDOM;
            for (int c = 0; c < 3; c++)
            begin
                pick = $urandom_range(0, 9);
                if (pick <= 1)
                    run_command(MODE_RESET, 8'($urandom_range(0, 255)));
                else if (pick <= 4)
                    run_command(MODE_WRITE, 8'($urandom_range(0, 255)));
                else if (pick <= 7)
                    run_command(MODE_READ, 8'($urandom_range(0, 255)));
                else if (pick == 8)
                    send_tick(MODE_TICK, 8'($urandom_range(0, 255)), pick_line());
                else
                    send_tick(3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)),
                              8'($urandom_range(0, 255)), pick_line());
                // a few idle ticks between commands
                repeat ($urandom_range(0, 2))
                    send_tick(MODE_TICK, 8'($urandom_range(0, 255)), pick_line());
            end
            drain();
        end

        if (sb.expected_q.size() != 0)
        begin
            $display("%0d expected results never arrived", sb.expected_q.size());
            sb.failures += sb.expected_q.size();
        end
        $display("Covered %0d ticks and %0d finished commands, %0d of them temperature reads,",
                 sb.ticks, sb.done_count, sb.temp_count);
        $display("over %0d timing setups; %0d result transactions checked, %0d failures.",
                 settings, sb.checked, sb.failures);
        if (sb.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
rtl/core/owm_pkg.sv
rtl/core/owm_cfg.sv
rtl/core/owm_seq.sv
rtl/core/one_wire_temperature_master.sv
rtl/core/owm_checker.sv
test/tb_one_wire_temperature_master.sv
